/* design/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is held
`define LBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked property that is also checked through reset
`define LBS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* design/lbs_pkg.sv */
// shared types, constants and arithmetic helpers of the skinning unit
`timescale 1ns / 1ps
package lbs_pkg;

    localparam int WORDS_PER_BONE = 12;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = 2;
    localparam int QCNT_W         = 3;

    localparam logic CMD_PALETTE   = 1'b0;
    localparam logic CMD_INFLUENCE = 1'b1;

    // one classified command handed from front to back
    typedef struct packed {
        logic        is_pal;
        logic        pal_ok;
        logic [5:0]  pal_bone;
        logic [3:0]  pal_word;
        logic [31:0] pal_value;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic        is_normal;
        logic        usable;
        logic [7:0]  bone;
        logic [15:0] weight;
        logic        last;
    } lbs_cmd_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] sign_sat32(input logic neg, input logic [63:0] q);
        if (neg) begin
            if (q > 64'd2147483648) begin
                return 32'h8000_0000;
            end
            return ~q[31:0] + 32'd1;
        end
        if (q > 64'd2147483647) begin
            return 32'h7fff_ffff;
        end
        return q[31:0];
    endfunction

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            return a[63] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
        end
        return s;
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

/* design/lbs_front.sv */
// input side: classifies each word and queues it for the datapath
`timescale 1ns / 1ps
module lbs_front
    import lbs_pkg::*;
#(
    parameter int MAX_BONES = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [175:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,
    input  logic [6:0]   bone_count,
    output logic         q_valid,
    output lbs_cmd_t     q_head,
    input  logic         q_ready
);

    lbs_cmd_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wptr_reg, wptr_next;
    logic [QPTR_W-1:0]    rptr_reg, rptr_next;
    logic [QCNT_W-1:0]    count_reg, count_next;
    lbs_cmd_t             cls;
    logic                 push, pop;

    // field decode and classification
    always_comb begin
        cls.is_pal    = (s_tuser[0] == CMD_PALETTE);
        cls.pal_bone  = s_tdata[5:0];
        cls.pal_word  = s_tdata[9:6];
        cls.pal_value = s_tdata[41:10];
        cls.pos_x     = s_tdata[73:42];
        cls.pos_y     = s_tdata[105:74];
        cls.pos_z     = s_tdata[137:106];
        cls.bone      = s_tdata[145:138];
        cls.weight    = s_tdata[169:154];
        cls.is_normal = s_tuser[1];
        cls.last      = s_tlast;
        cls.pal_ok    = ({3'b0, s_tdata[5:0]} < 9'(MAX_BONES))
                     && (s_tdata[9:6] < 4'(WORDS_PER_BONE));
        cls.usable    = ({1'b0, s_tdata[153:138]} < {10'b0, bone_count})
                     && ({1'b0, s_tdata[153:138]} < 17'(MAX_BONES))
                     && !s_tdata[169] && (s_tdata[169:154] != 16'd0);
    end

    assign s_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_head   = entry_reg[rptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= cls;
        end
    end

endmodule

/* design/lbs_div.sv */
// restoring divider, one quotient bit a cycle
`timescale 1ns / 1ps
module lbs_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [63:0] quo
);

    logic [31:0] rem_reg;
    logic [63:0] quo_reg;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial, diff;
    logic        ge;

    assign trial = {rem_reg, quo_reg[63]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});
    assign done  = done_reg;
    assign quo   = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 6'd63);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[31:0] : trial[31:0];
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

endmodule

/* design/lbs_isqrt.sv */
// integer square root, two radicand bits a cycle
`timescale 1ns / 1ps
module lbs_isqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] n,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] n_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;
    assign done  = done_reg;
    assign root  = res_reg[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 5'd31);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= n;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            if (n_reg >= trial) begin
                n_reg   <= n_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

/* design/lbs_back.sv */
// datapath side: palette store, transform pipeline, accumulate, divide, normalise
`timescale 1ns / 1ps
module lbs_back
    import lbs_pkg::*;
#(
    parameter int MAX_BONES = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  lbs_cmd_t    q_head,
    output logic        q_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,
    output logic        m_tuser
);

    localparam int PAL_DEPTH = MAX_BONES * WORDS_PER_BONE;
    localparam int ADDR_W    = $clog2(PAL_DEPTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_XF   = 4'd1;
    localparam logic [3:0] S_FIN  = 4'd2;
    localparam logic [3:0] S_DST  = 4'd3;
    localparam logic [3:0] S_DWT  = 4'd4;
    localparam logic [3:0] S_SQ   = 4'd5;
    localparam logic [3:0] S_IST  = 4'd6;
    localparam logic [3:0] S_IWT  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [31:0]        pal_mem [PAL_DEPTH];

    logic [3:0]         state_reg, state_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [1:0]         comp_reg, comp_next;
    logic               norm_reg, norm_next;
    lbs_cmd_t           cur_reg;
    logic [63:0]        acc_reg [3];
    logic [31:0]        ws_reg;
    logic [31:0]        r_reg [3];
    logic [63:0]        sq_reg, sqp_reg;
    logic               pt_reg;

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic [1:0]         row1_reg, row2_reg;
    logic [1:0]         col1_reg, col2_reg, col3_reg, col4_reg;
    logic signed [31:0] rdata_reg;
    logic signed [63:0] prod_reg, s_reg;
    logic signed [31:0] ts_reg;
    logic signed [47:0] wp_reg;

    logic               m_valid_reg;
    logic [95:0]        m_data_reg;
    logic               m_user_reg;

    logic               issue, out_load, pop;
    logic [11:0]        wr_addr12, rd_addr12;
    logic [3:0]         rd_word;
    logic signed [31:0] pos_sel;
    logic signed [63:0] mul_full, term;
    logic [32:0]        ws_sum;

    logic               div_start, div_done;
    logic [63:0]        div_num, div_q;
    logic [31:0]        div_den;
    logic               isq_start, isq_done;
    logic [31:0]        isq_root;

    lbs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_q)
    );

    lbs_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (isq_start),
        .n       (sq_reg),
        .done    (isq_done),
        .root    (isq_root)
    );

    assign issue    = (state_reg == S_XF) && (cnt_reg != 4'd12);
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_tready);
    assign pop      = q_valid && q_ready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // bone * 12 + word
    assign wr_addr12 = ({6'b0, q_head.pal_bone} << 3) + ({6'b0, q_head.pal_bone} << 2)
                     + {8'b0, q_head.pal_word};
    assign rd_word   = ({2'b0, cnt_reg[1:0]} << 1) + {2'b0, cnt_reg[1:0]}
                     + {2'b0, cnt_reg[3:2]};
    assign rd_addr12 = ({4'b0, cur_reg.bone} << 3) + ({4'b0, cur_reg.bone} << 2)
                     + {8'b0, rd_word};

    always_comb begin
        case (row1_reg)
            2'd0:    pos_sel = $signed(cur_reg.pos_x);
            2'd1:    pos_sel = $signed(cur_reg.pos_y);
            default: pos_sel = $signed(cur_reg.pos_z);
        endcase
    end

    assign mul_full = pos_sel * rdata_reg;
    assign term     = (row2_reg == 2'd3) ? prod_reg : (prod_reg >>> FRAC_BITS);
    assign ws_sum   = {1'b0, ws_reg} + {17'b0, q_head.weight};

    // divider operands: weighted sum over weight, or component over length
    always_comb begin
        if (norm_reg) begin
            div_num = ({32'b0, mag32(r_reg[comp_reg])} << FRAC_BITS)
                    + {33'b0, sq_reg[31:1]};
            div_den = sq_reg[31:0];
        end else begin
            div_num = mag64(acc_reg[comp_reg]) + {33'b0, ws_reg[31:1]};
            div_den = ws_reg;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        norm_next  = norm_reg;
        q_ready    = 1'b0;
        div_start  = 1'b0;
        isq_start  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                q_ready = 1'b1;
                if (q_valid && !q_head.is_pal) begin
                    if (q_head.usable) begin
                        state_next = S_XF;
                        cnt_next   = '0;
                    end else if (q_head.last) begin
                        state_next = S_FIN;
                    end
                end
            end
            S_XF: begin
                if (cnt_reg != 4'd12) begin
                    cnt_next = cnt_reg + 4'd1;
                end else if (!(v1_reg || v2_reg || v3_reg || v4_reg)) begin
                    state_next = cur_reg.last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                comp_next = '0;
                norm_next = 1'b0;
                state_next = (ws_reg == '0) ? S_OUT : S_DST;
            end
            S_DST: begin
                div_start  = 1'b1;
                state_next = S_DWT;
            end
            S_DWT: begin
                if (div_done) begin
                    comp_next = comp_reg + 2'd1;
                    if (comp_reg != 2'd2) begin
                        state_next = S_DST;
                    end else if (!norm_reg && cur_reg.is_normal) begin
                        state_next = S_SQ;
                        cnt_next   = '0;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_SQ: begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd3) begin
                    state_next = S_IST;
                end
            end
            S_IST: begin
                isq_start  = 1'b1;
                state_next = S_IWT;
            end
            S_IWT: begin
                if (isq_done) begin
                    if (isq_root == '0) begin
                        state_next = S_OUT;
                    end else begin
                        norm_next  = 1'b1;
                        comp_next  = '0;
                        state_next = S_DST;
                    end
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // palette store, one write and one registered read
    always_ff @(posedge aclk) begin
        if (pop && q_head.is_pal && q_head.pal_ok) begin
            pal_mem[wr_addr12[ADDR_W-1:0]] <= q_head.pal_value;
        end
        rdata_reg <= $signed(pal_mem[rd_addr12[ADDR_W-1:0]]);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            comp_reg    <= '0;
            norm_reg    <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            ws_reg      <= '0;
            for (int i = 0; i < 3; i++) begin
                acc_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
            norm_reg  <= norm_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg && (row2_reg == 2'd3);
            v4_reg    <= v3_reg;
            if (out_load) begin
                m_valid_reg <= 1'b1;
                ws_reg      <= '0;
                for (int i = 0; i < 3; i++) begin
                    acc_reg[i] <= '0;
                end
            end else begin
                if (m_tready) begin
                    m_valid_reg <= 1'b0;
                end
                if (pop && !q_head.is_pal && q_head.usable) begin
                    ws_reg <= ws_sum[32] ? 32'hffff_ffff : ws_sum[31:0];
                end
                for (int i = 0; i < 3; i++) begin
                    if (v4_reg && col4_reg == 2'(i)) begin
                        acc_reg[i] <= sat_add64(acc_reg[i], 64'(wp_reg));
                    end
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= q_head;
        end
        row1_reg <= cnt_reg[1:0];
        col1_reg <= cnt_reg[3:2];
        row2_reg <= row1_reg;
        col2_reg <= col1_reg;
        col3_reg <= col2_reg;
        col4_reg <= col3_reg;
        if (v1_reg) begin
            if (row1_reg == 2'd3) begin
                prod_reg <= cur_reg.is_normal ? 64'sd0 : 64'(rdata_reg);
            end else begin
                prod_reg <= mul_full;
            end
        end
        if (v2_reg) begin
            s_reg  <= (row2_reg == 2'd0) ? term : s_reg + term;
            ts_reg <= $signed(sat32(s_reg + term));
        end
        wp_reg <= ts_reg * $signed(cur_reg.weight);

        if (state_reg == S_FIN) begin
            pt_reg <= (ws_reg == '0);
        end
        if (state_reg == S_DWT && div_done) begin
            r_reg[comp_reg] <= sign_sat32(norm_reg ? r_reg[comp_reg][31]
                                                   : acc_reg[comp_reg][63], div_q);
        end
        if (state_reg == S_SQ) begin
            if (cnt_reg != 4'd3) begin
                sqp_reg <= {32'b0, mag32(r_reg[cnt_reg[1:0]])}
                         * {32'b0, mag32(r_reg[cnt_reg[1:0]])};
            end
            sq_reg <= (cnt_reg == 4'd0) ? 64'd0 : sq_reg + sqp_reg;
        end
        if (state_reg == S_IWT && isq_done) begin
            // length sits in the low half of sq_reg for the divider
            sq_reg <= {32'b0, isq_root};
            if (isq_root == '0) begin
                for (int i = 0; i < 3; i++) begin
                    r_reg[i] <= '0;
                end
            end
        end
        if (out_load) begin
            m_user_reg <= pt_reg;
            if (pt_reg) begin
                m_data_reg <= {cur_reg.pos_z, cur_reg.pos_y, cur_reg.pos_x};
            end else begin
                m_data_reg <= {r_reg[2], r_reg[1], r_reg[0]};
            end
        end
    end

endmodule

/* design/linear_blend_skinning_unit.sv */
// linear blend skinning unit: top level with configuration register
// palette word: written from the queue while idle; influence: 12 palette reads,
//   one multiplier, four stage drain; queue of 4 words in front takes input meanwhile
// last influence adds three 64-step divisions unless the weight sum is zero, and a normal
//   adds squares, a 32-step square root and three more divisions unless the length is zero
// result sits in an output register; the next word is taken while it waits
// reset (aresetn low, synchronous) empties the queue, clears the sums and bone_count;
//   palette contents are kept and are undefined until written
`timescale 1ns / 1ps
module linear_blend_skinning_unit
    import lbs_pkg::*;
#(
    parameter int MAX_BONES = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration: bone_count
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata,
    // input words
    input  logic         s_tvalid,
    output logic         s_tready,
    // palette_bone, palette_word, palette_value, pos_x, pos_y, pos_z,
    // infl_bone, infl_weight, zero fill
    input  logic [175:0] s_tdata,
    // cmd, is_normal
    input  logic [1:0]   s_tuser,
    // last_influence
    input  logic         s_tlast,
    // result words
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y, out_z
    output logic [95:0]  m_tdata,
    // passthrough
    output logic         m_tuser
);

    logic [6:0] bone_count_reg, bone_count_next;
    logic       q_valid, q_ready;
    lbs_cmd_t   q_head;

    // bone_count is to change only while the unit is idle; the block itself does not enforce it
    assign bone_count_next = cfg_we ? cfg_wdata : bone_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bone_count_reg <= '0;
        end else begin
            bone_count_reg <= bone_count_next;
        end
    end

    // front: decode, range checks on bone, weight and palette address, command queue
    lbs_front #(
        .MAX_BONES (MAX_BONES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .bone_count (bone_count_reg),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_ready    (q_ready)
    );

    // back: palette, transform and weighting, final divide and normalise
    lbs_back #(
        .MAX_BONES (MAX_BONES),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_ready  (q_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* design/lbs_checker.sv */
// port-level checks of the skinning unit, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lbs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tuser
);

    logic [3:0] pend_reg, pend_next;
    logic       in_last, out_word;

    // results owed: last influences taken minus result words delivered
    assign in_last   = s_tvalid && s_tready && s_tuser[0] && s_tlast;
    assign out_word  = m_tvalid && m_tready;
    assign pend_next = pend_reg + 4'(in_last) - 4'(out_word);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    `LBS_ASSERT_RST(a_reset_idle, !aresetn |=> !m_tvalid, "result valid after reset")
    `LBS_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `LBS_ASSERT(a_no_spurious, out_word |-> pend_reg != 4'd0, "result without a last influence")
    `LBS_ASSERT(a_bounded, pend_reg <= 4'd6, "more results owed than queue and stages hold")

endmodule

bind linear_blend_skinning_unit lbs_checker u_lbs_checker (.*);

/* tb/sv/tb_linear_blend_skinning_unit.sv */
// testbench for the linear blend skinning unit: random and directed words against a predictor
`timescale 1ns / 1ps
module tb_linear_blend_skinning_unit;
    import lbs_pkg::*;

    localparam int NBONES = 64;
    localparam int FRACB  = 16;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct {
        logic [31:0] x, y, z;
        logic        pass;
    } skin_result_t;

    // expected deformed vertices, in order
    class skin_scoreboard;
        logic [31:0] palette [NBONES*12];
        longint      acc [3];
        longint unsigned wsum;
        int unsigned bone_cnt;
        skin_result_t pending [$];
        int errors, checked;

        function new();
            foreach (palette[i]) palette[i] = '0;
            acc = '{0, 0, 0};
            wsum = 0;
            bone_cnt = 0;
            errors = 0;
            checked = 0;
        endfunction

        function automatic longint fdiv(longint a);
            return a >>> FRACB;
        endfunction

        function automatic longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function automatic longint sadd(longint a, longint b);
            longint s;
            s = a + b;
            if ((a < 0) == (b < 0) && (s < 0) != (a < 0))
                return (a < 0) ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
            return s;
        endfunction

        function automatic longint unsigned umag(longint v);
            return v < 0 ? longint'(0) - v : v;
        endfunction

        function automatic longint signed_clip(bit neg, longint unsigned q);
            if (neg) return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
            return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
        endfunction

        function automatic longint unsigned root(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function void note_input(logic [175:0] d, logic [1:0] u, logic lst);
            logic [5:0]  pb;
            logic [3:0]  pw;
            longint      p [3];
            longint      t, w, r [3];
            longint unsigned sq, len, q;
            int          bone;
            skin_result_t e;
            pb = d[5:0];
            pw = d[9:6];
            if (u[0] == CMD_PALETTE) begin
                if (pw < 12) palette[pb*12 + pw] = d[41:10];
                return;
            end
            p[0] = longint'($signed(d[73:42]));
            p[1] = longint'($signed(d[105:74]));
            p[2] = longint'($signed(d[137:106]));
            bone = d[153:138];
            w = longint'($signed(d[169:154]));
            if (bone < bone_cnt && bone < NBONES && w > 0) begin
                for (int c = 0; c < 3; c++) begin
                    t = 0;
                    for (int rr = 0; rr < 3; rr++)
                        t += fdiv(p[rr] * longint'($signed(palette[bone*12 + rr*3 + c])));
                    if (!u[1]) t += longint'($signed(palette[bone*12 + 9 + c]));
                    acc[c] = sadd(acc[c], clip32(t) * w);
                end
                wsum = (wsum + w > 64'hffff_ffff) ? 64'hffff_ffff : wsum + w;
            end
            if (!lst) return;
            if (wsum == 0) begin
                e.x = d[73:42];
                e.y = d[105:74];
                e.z = d[137:106];
                e.pass = 1'b1;
            end else begin
                for (int c = 0; c < 3; c++)
                    r[c] = signed_clip(acc[c] < 0, (umag(acc[c]) + wsum / 2) / wsum);
                if (u[1]) begin
                    sq = 0;
                    for (int c = 0; c < 3; c++) sq += umag(r[c]) * umag(r[c]);
                    len = root(sq);
                    for (int c = 0; c < 3; c++) begin
                        if (len == 0) begin
                            r[c] = 0;
                        end else begin
                            q = ((umag(r[c]) << FRACB) + len / 2) / len;
                            r[c] = signed_clip(r[c] < 0, q);
                        end
                    end
                end
                e.x = r[0][31:0];
                e.y = r[1][31:0];
                e.z = r[2][31:0];
                e.pass = 1'b0;
            end
            pending.insert(pending.size(), e);
            acc = '{0, 0, 0};
            wsum = 0;
        endfunction

        function void check_result(logic [95:0] d, logic pass);
            skin_result_t e;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", d);
                return;
            end
            e = pending.pop_front();
            if (d !== {e.z, e.y, e.x} || pass !== e.pass) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d: expected %h/%h/%h pt %b, got %h/%h/%h pt %b",
                             checked, e.x, e.y, e.z, e.pass,
                             d[31:0], d[63:32], d[95:64], pass);
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [6:0]   cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic         m_tuser;

    skin_scoreboard sb;
    bit  quiet;          // no idling in the closing stretch
    int  idle_cycles = 0;
    bit  timed_out;
    int  vertices_sent, palette_sent;
    bit  written [NBONES];

    linear_blend_skinning_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // result side: random stall bursts, compare each accepted word
    initial begin
        int burst;
        m_tready = 1'b0;
        burst = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
            if (burst > 0) begin
                burst--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", idle_cycles);
                $display("linear_blend_skinning_unit: mismatch");
                $finish;
            end
        end
    end

    // send one word, with an optional random gap ahead of it
    task automatic send_word(logic [175:0] d, logic [1:0] u, logic lst);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= d;
        s_tuser  <= u;
        s_tlast  <= lst;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(d, u, lst);
        if (u[0] == CMD_PALETTE) palette_sent++;
        else if (lst) vertices_sent++;
    endtask

    task automatic send_palette(int bone, int word, logic [31:0] val, logic lst);
        logic [175:0] d;
        d = '0;
        d[5:0]   = bone[5:0];
        d[9:6]   = word[3:0];
        d[41:10] = val;
        d[175:170] = 6'($urandom);  // fill noise is outside the fields, keep it zero
        d[175:170] = '0;
        send_word(d, {1'b0, CMD_PALETTE}, lst);
    endtask

    task automatic send_influence(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                  logic nrm, logic [15:0] bone, logic [15:0] w, logic lst);
        logic [175:0] d;
        d = '0;
        d[5:0]     = 6'($urandom);
        d[9:6]     = 4'($urandom);
        d[41:10]   = $urandom;
        d[73:42]   = x;
        d[105:74]  = y;
        d[137:106] = z;
        d[153:138] = bone;
        d[169:154] = w;
        send_word(d, {nrm, CMD_INFLUENCE}, lst);
    endtask

    // random matrix entry: mostly near identity scale, sometimes extreme
    function automatic logic [31:0] rand_matrix_word(int word);
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: begin
                if (word >= 9) return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
                return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
            end
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom;
            3: return 32'h0;
            default: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
        endcase
    endfunction

    // usable, out of range or non-positive weights; usable bones only among written ones
    task automatic send_vertex(int n_infl, int nbones);
        logic nrm;
        logic [31:0] x, y, z;
        logic [15:0] b, w;
        int k;
        for (int i = 0; i < n_infl; i++) begin
            nrm = (i == 0) ? 1'($urandom) : ($urandom_range(0, 3) == 0 ? ~nrm : nrm);
            x = rand_coord();
            y = rand_coord();
            z = rand_coord();
            k = $urandom_range(0, 19);
            if (k == 0) b = 16'($urandom);
            else if (k == 1) b = 16'(nbones + $urandom_range(0, 3));
            else b = 16'($urandom_range(0, nbones - 1));
            // unwritten bones inside the register fall back to the directed ones
            if (b < NBONES && !written[b] && b < sb.bone_cnt)
                b = (sb.bone_cnt > 1) ? 16'($urandom_range(0, 1)) : 16'(NBONES);
            k = $urandom_range(0, 19);
            if (k == 0) w = 16'h8000;
            else if (k == 1) w = 16'h0;
            else if (k == 2) w = 16'h7fff;
            else w = 16'($urandom_range(1, 16'h4000));
            send_influence(x, y, z, nrm, b, w, i == n_infl - 1);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    task automatic write_bone_count(logic [6:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.bone_cnt = v;
    endtask

    initial begin
        int nb;
        logic [6:0] counts [4];
        sb = new();
        quiet = 1'b0;
        vertices_sent = 0;
        palette_sent = 0;
        foreach (written[i]) written[i] = 1'b0;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        s_tlast   = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: bone 0 identity plus translation, bone 1 extreme entries
        for (int wd = 0; wd < 12; wd++)
            send_palette(0, wd, (wd == 0 || wd == 4 || wd == 8) ? 32'h0001_0000 :
                         (wd >= 9 ? 32'h0002_0000 : 32'h0), wd == 3);
        for (int wd = 0; wd < 12; wd++)
            send_palette(1, wd, wd[0] ? 32'h7fff_ffff : 32'h8000_0000, 1'b0);
        written[0] = 1'b1;
        written[1] = 1'b1;
        send_palette(63, 12, 32'hdead_beef, 1'b1);    // word index out of range
        send_palette(63, 15, 32'h1234_5678, 1'b0);
        // bone_count still zero: everything passes through
        send_influence(32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b1, 16'd0, 16'h4000, 1'b1);
        wait_drained();
        write_bone_count(7'd2);
        send_influence(32'h0001_0000, 32'h0, 32'hffff_0000, 1'b0, 16'd0, 16'h4000, 1'b1);
        send_influence(32'h0001_0000, 32'h0002_0000, 32'h0, 1'b1, 16'd0, 16'h2000, 1'b1);
        send_influence(32'h0, 32'h0, 32'h0, 1'b1, 16'd0, 16'h4000, 1'b1);   // zero normal
        send_influence(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 16'd1, 16'h7fff, 1'b0);
        send_palette(5, 0, 32'h0, 1'b1);             // palette word mid-vertex
        send_influence(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 16'd1, 16'h7fff, 1'b0);
        send_influence(32'h1, 32'h2, 32'h3, 1'b1, 16'd0, 16'h0001, 1'b1);
        send_influence(32'h5, 32'h6, 32'h7, 1'b0, 16'hffff, 16'h8000, 1'b1);  // all skipped
        send_influence(32'h5, 32'h6, 32'h7, 1'b0, 16'd0, 16'hffff, 1'b1);
        wait_drained();

        // random phases at several bone counts, extremes included
        counts = '{7'd64, 7'd1, 7'd37, 7'd127};
        for (int ph = 0; ph < 4; ph++) begin
            write_bone_count(counts[ph]);
            nb = (counts[ph] > NBONES) ? NBONES : counts[ph];
            for (int i = 0; i < 50; i++) begin
                if (ph == 3 && i == 38) quiet = 1'b1;
                if ($urandom_range(0, 7) == 0) begin
                    int bsel;
                    bsel = $urandom_range(0, 3) == 0 ? $urandom_range(0, 63) : i % nb;
                    for (int wd = 0; wd < 12; wd++)
                        send_palette(bsel, wd, rand_matrix_word(wd), 1'($urandom));
                    written[bsel] = 1'b1;
                end else if ($urandom_range(0, 15) == 0) begin
                    send_palette($urandom_range(0, 63), $urandom_range(12, 15), $urandom,
                                 1'($urandom));
                end
                send_vertex($urandom_range(1, 4), nb);
            end
            wait_drained();
        end

        $display("sent %0d vertices and %0d palette words over six bone_count settings",
                 vertices_sent, palette_sent);
        $display("checked %0d results, %0d mismatched", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("linear_blend_skinning_unit: match");
        end else begin
            $display("linear_blend_skinning_unit: mismatch");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+design
design/lbs_pkg.sv
design/lbs_front.sv
design/lbs_div.sv
design/lbs_isqrt.sv
design/lbs_back.sv
design/linear_blend_skinning_unit.sv
design/lbs_checker.sv
tb/sv/tb_linear_blend_skinning_unit.sv
